### design/count_min_sketch_top_k_defines.svh
// assertion macros shared by the checker
`ifndef COUNT_MIN_SKETCH_TOP_K_DEFINES_SVH
`define COUNT_MIN_SKETCH_TOP_K_DEFINES_SVH

// same-cycle implication
`define CMS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("cms port check failed");

// next-cycle implication
`define CMS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("cms port check failed");

`endif

### design/cms_pkg.sv
package cms_pkg;

	typedef enum logic [1:0] {
		OP_UPDATE = 2'd0,
		OP_QUERY  = 2'd1,
		OP_DUMP   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] key;
	} req_t;

	typedef struct packed {
		logic [31:0] estimate;
		logic        tracked;
		logic        evicted_valid;
		logic [63:0] evicted_key;
		logic        entry_valid;
		logic [63:0] entry_key;
		logic [31:0] entry_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic rot;
		logic clr;
		logic wr;
	} list_ctl_t;

	localparam logic [63:0] SEED [8] = '{
		64'h9e3779b97f4a7c15, 64'h517cc1b727220a95,
		64'hbf58476d1ce4e5b9, 64'h94d049bb133111eb,
		64'h6c62272e07bb0142, 64'had9d7571e84e23c2,
		64'h5c4a4a3561d6f2ea, 64'h9b10f7b08e98c4fa
	};

	localparam logic [63:0] MIX1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX2 = 64'h94d049bb133111eb;
	localparam logic [31:0] CNT_MAX = 32'hffffffff;
	localparam int MAX_RES = 16;

endpackage

### design/cms_hash.sv
module cms_hash #(
	parameter int WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [63:0]                           key,
	input  logic [2:0]                            row,
	output logic                                  done,
	output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] idx
);

	localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam logic [17:0] WV = 18'(WIDTH);

	typedef enum logic [2:0] {
		H_IDLE = 3'b001,
		H_MUL  = 3'b010,
		H_MOD  = 3'b100
	} hst_t;

	hst_t        st_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] prod_q;
	logic [1:0]  mc_q;
	logic        pass_q;
	logic [16:0] rem_q;
	logic [2:0]  bc_q;
	logic        done_q;

	logic [63:0] c;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] mres;
	logic [63:0] h0;
	logic [17:0] t;
	logic [16:0] rem_n;

	assign c    = pass_q ? cms_pkg::MIX2 : cms_pkg::MIX1;
	assign ma   = (mc_q == 2'd2) ? x_q[63:32] : x_q[31:0];
	assign mb   = (mc_q == 2'd1) ? c[63:32] : c[31:0];
	assign mres = acc_q + {prod_q[31:0], 32'd0};
	assign h0   = key ^ cms_pkg::SEED[row];

	// eight remainder steps, msb first
	always_comb begin
		t = {1'b0, rem_q};
		for (int i = 0; i < 8; i++) begin
			t = {t[16:0], x_q[63-i]};
			if (t >= WV) begin
				t = t - WV;
			end
		end
		rem_n = t[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= H_IDLE;
			mc_q   <= 2'd0;
			pass_q <= 1'b0;
			bc_q   <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				H_IDLE: begin
					if (start) begin
						st_q   <= H_MUL;
						mc_q   <= 2'd0;
						pass_q <= 1'b0;
					end
				end
				H_MUL: begin
					mc_q <= mc_q + 2'd1;
					if (mc_q == 2'd3) begin
						if (pass_q) begin
							st_q <= H_MOD;
							bc_q <= 3'd0;
						end
						pass_q <= 1'b1;
					end
				end
				H_MOD: begin
					bc_q <= bc_q + 3'd1;
					if (bc_q == 3'd7) begin
						st_q   <= H_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		case (st_q)
			H_IDLE: begin
				x_q   <= (h0 >> 30) ^ h0;
				rem_q <= '0;
			end
			H_MUL: begin
				case (mc_q)
					2'd1: acc_q <= prod_q;
					2'd2: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
					2'd3: x_q <= pass_q ? ((mres >> 31) ^ mres) : ((mres >> 27) ^ mres);
					default: acc_q <= acc_q;
				endcase
			end
			H_MOD: begin
				rem_q <= rem_n;
				x_q   <= {x_q[55:0], 8'd0};
			end
			default: x_q <= x_q;
		endcase
	end

	assign done = done_q;
	assign idx  = rem_q[IW-1:0];

endmodule

### design/cms_row.sv
module cms_row #(
	parameter int WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] idx,
	input  logic                                  inc,
	input  logic                                  clr,
	input  logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0] caddr,
	output logic [31:0]                           rd,
	output logic [31:0]                           nv
);

	logic [31:0] mem [WIDTH];
	logic [31:0] rd_q;

	// saturating increment
	assign nv = (rd_q == cms_pkg::CNT_MAX) ? rd_q : rd_q + 32'd1;
	assign rd = rd_q;

	always_ff @(posedge clk) begin
		rd_q <= mem[idx];
		if (clr) begin
			mem[caddr] <= '0;
		end else if (inc) begin
			mem[idx] <= nv;
		end
	end

endmodule

### design/cms_cell.sv
module cms_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cms_pkg::list_ctl_t    ctl,
	input  logic                  sel,
	input  logic [63:0]           nkey,
	input  logic [31:0]           ncnt,
	input  logic                  nvld,
	input  logic [63:0]           wkey,
	input  logic [31:0]           wcnt,
	output logic [63:0]           key,
	output logic [31:0]           cnt,
	output logic                  vld
);

	logic [63:0] key_q;
	logic [31:0] cnt_q;
	logic        vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.rot) begin
			vld_q <= nvld;
		end else if (ctl.wr && sel) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rot) begin
			key_q <= nkey;
			cnt_q <= ncnt;
		end else if (ctl.wr && sel) begin
			key_q <= wkey;
			cnt_q <= wcnt;
		end
	end

	assign key = key_q;
	assign cnt = cnt_q;
	assign vld = vld_q;

endmodule

### design/cms_list.sv
module cms_list #(
	parameter int TOP_K = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cms_pkg::list_ctl_t                    ctl,
	input  logic [((TOP_K > 1) ? $clog2(TOP_K) : 1)-1:0] widx,
	input  logic [63:0]                           wkey,
	input  logic [31:0]                           wcnt,
	output logic [63:0]                           head_key,
	output logic [31:0]                           head_cnt,
	output logic                                  head_vld,
	output logic                                  next_vld
);

	localparam int SW = (TOP_K > 1) ? $clog2(TOP_K) : 1;

	logic [63:0] kk [TOP_K];
	logic [31:0] cc [TOP_K];
	logic        vv [TOP_K];

	// ring: each cell takes its right neighbor, slot 0 wraps to the tail
	for (genvar i = 0; i < TOP_K; i++) begin : g_cell
		cms_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sel    (widx == SW'(i)),
			.nkey   (kk[(i + 1) % TOP_K]),
			.ncnt   (cc[(i + 1) % TOP_K]),
			.nvld   (vv[(i + 1) % TOP_K]),
			.wkey   (wkey),
			.wcnt   (wcnt),
			.key    (kk[i]),
			.cnt    (cc[i]),
			.vld    (vv[i])
		);
	end

	assign head_key = kk[0];
	assign head_cnt = cc[0];
	assign head_vld = vv[0];

	if (TOP_K > 1) begin : g_nxt
		assign next_vld = vv[1];
	end else begin : g_one
		assign next_vld = 1'b0;
	end

endmodule

### design/count_min_sketch_top_k.sv
// update/query: hash per row (one shared 32x32 multiplier), row min, list scan, result
// dump: a beat per listed slot up to MAX_RES as the ring turns once; one beat if empty
// clear: one beat, then a sweep of the counter rows
// one item at a time; next is taken once current beats are queued and any sweep is done
// reset: list emptied at once, counters swept before the first item
module count_min_sketch_top_k #(
	parameter int WIDTH = 1024,
	parameter int DEPTH = 4,
	parameter int TOP_K = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cms_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cms_pkg::rsp_t   rsp
);

	localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
	localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
	localparam int FW = $clog2(TOP_K + 1);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_HASH  = 9'b000000100,
		S_READ  = 9'b000001000,
		S_MIN   = 9'b000010000,
		S_SCAN  = 9'b000100000,
		S_DEC   = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_DUMP  = 9'b100000000
	} st_t;

	st_t                st_q;
	cms_pkg::op_t       op_q;
	logic [63:0]        key_q;
	logic [RW-1:0]      row_q;
	logic               hstart_q;
	logic               hdone;
	logic [IW-1:0]      hidx;
	logic [IW-1:0]      idx_q [DEPTH];
	logic [31:0]        rd [DEPTH];
	logic [31:0]        nv [DEPTH];
	logic [31:0]        est_q;
	logic [31:0]        vsel;
	logic [SW-1:0]      s_q;
	logic [SW-1:0]      fidx_q;
	logic [SW-1:0]      lo_q;
	logic [SW-1:0]      widx;
	logic               fnd_q;
	logic [FW-1:0]      fill_q;
	logic [31:0]        locnt_q;
	logic [63:0]        lokey_q;
	cms_pkg::rsp_t      res_q;
	cms_pkg::rsp_t      res_d;
	cms_pkg::rsp_t      dent;
	cms_pkg::rsp_t      rsp_q;
	logic               rsp_vld_q;
	logic [IW-1:0]      clr_q;
	logic               free;
	logic               acc;
	logic               inc_en;
	logic               clr_en;
	logic               match;
	logic               emit;
	logic               dgo;
	logic               load;
	logic               last_row;
	logic               last_slot;
	cms_pkg::list_ctl_t lctl;
	logic [63:0]        wkey;
	logic [31:0]        wcnt;
	logic [63:0]        hkey;
	logic [31:0]        hcnt;
	logic               hvld;
	logic               nvld;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (st_q != S_IDLE);
	assign free      = !rsp_vld_q || !rsp_stall;
	assign last_row  = (row_q == RW'(DEPTH - 1));
	assign last_slot = (s_q == SW'(TOP_K - 1));
	assign vsel      = (op_q == cms_pkg::OP_UPDATE) ? nv[row_q] : rd[row_q];
	assign inc_en    = (st_q == S_MIN) && last_row && (op_q == cms_pkg::OP_UPDATE);
	assign clr_en    = (st_q == S_CLEAR);
	assign match     = hvld && (hkey == key_q);
	assign emit      = ((s_q == '0) && !hvld) || (hvld && (int'(s_q) < cms_pkg::MAX_RES));
	assign dgo       = !emit || free;
	assign load      = ((st_q == S_EMIT) && free) || ((st_q == S_DUMP) && emit && dgo);

	cms_hash #(.WIDTH(WIDTH)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hstart_q),
		.key    (key_q),
		.row    (3'(row_q)),
		.done   (hdone),
		.idx    (hidx)
	);

	for (genvar r = 0; r < DEPTH; r++) begin : g_row
		cms_row #(.WIDTH(WIDTH)) u_row (
			.clk   (clk),
			.idx   (idx_q[r]),
			.inc   (inc_en),
			.clr   (clr_en),
			.caddr (clr_q),
			.rd    (rd[r]),
			.nv    (nv[r])
		);
	end

	cms_list #(.TOP_K(TOP_K)) u_list (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (lctl),
		.widx     (widx),
		.wkey     (wkey),
		.wcnt     (wcnt),
		.head_key (hkey),
		.head_cnt (hcnt),
		.head_vld (hvld),
		.next_vld (nvld)
	);

	// list control (rotation, clear, admission) and the result beat for update, query and clear
	always_comb begin
		lctl          = '0;
		lctl.rot      = (st_q == S_SCAN) || ((st_q == S_DUMP) && dgo);
		lctl.clr      = acc && (req.op == cms_pkg::OP_CLEAR);
		widx          = '0;
		wkey          = key_q;
		wcnt          = est_q;
		res_d         = '0;
		res_d.last    = 1'b1;
		if (st_q == S_DEC) begin
			res_d.estimate = est_q;
			if (op_q == cms_pkg::OP_UPDATE) begin
				res_d.tracked = 1'b1;
				if (fnd_q) begin
					lctl.wr = 1'b1;
					widx    = fidx_q;
				end else if (fill_q < FW'(TOP_K)) begin
					lctl.wr = 1'b1;
					widx    = fill_q[SW-1:0];
				end else if (est_q > locnt_q) begin
					lctl.wr             = 1'b1;
					widx                = lo_q;
					res_d.evicted_valid = 1'b1;
					res_d.evicted_key   = lokey_q;
				end else begin
					res_d.tracked = 1'b0;
				end
			end else begin
				res_d.tracked = fnd_q;
			end
		end
	end

	always_comb begin
		dent = '0;
		if (hvld && (int'(s_q) < cms_pkg::MAX_RES)) begin
			dent.entry_valid = 1'b1;
			dent.entry_key   = hkey;
			dent.entry_count = hcnt;
			dent.last        = last_slot || !nvld || (int'(s_q) == cms_pkg::MAX_RES - 1);
		end else begin
			dent.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_CLEAR;
			clr_q     <= '0;
			row_q     <= '0;
			s_q       <= '0;
			hstart_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			hstart_q <= 1'b0;
			if (load) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(WIDTH - 1)) begin
						clr_q <= '0;
						st_q  <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						case (req.op)
							cms_pkg::OP_UPDATE, cms_pkg::OP_QUERY: begin
								hstart_q <= 1'b1;
								row_q    <= '0;
								st_q     <= S_HASH;
							end
							cms_pkg::OP_DUMP: begin
								s_q  <= '0;
								st_q <= S_DUMP;
							end
							default: st_q <= S_EMIT;
						endcase
					end
				end
				S_HASH: begin
					if (hdone) begin
						if (last_row) begin
							row_q <= '0;
							st_q  <= S_READ;
						end else begin
							row_q    <= row_q + RW'(1);
							hstart_q <= 1'b1;
						end
					end
				end
				S_READ: st_q <= S_MIN;
				S_MIN: begin
					row_q <= row_q + RW'(1);
					if (last_row) begin
						row_q <= '0;
						s_q   <= '0;
						st_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					s_q <= s_q + SW'(1);
					if (last_slot) begin
						st_q <= S_DEC;
					end
				end
				S_DEC: st_q <= S_EMIT;
				S_EMIT: begin
					if (free) begin
						st_q <= (op_q == cms_pkg::OP_CLEAR) ? S_CLEAR : S_IDLE;
					end
				end
				S_DUMP: begin
					if (dgo) begin
						s_q <= s_q + SW'(1);
						if (last_slot) begin
							st_q <= S_IDLE;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_q  <= req.op;
			key_q <= req.key;
		end
		for (int r = 0; r < DEPTH; r++) begin
			if ((st_q == S_HASH) && hdone && (row_q == RW'(r))) begin
				idx_q[r] <= hidx;
			end
		end
		if (st_q == S_MIN) begin
			est_q <= ((row_q == '0) || (vsel < est_q)) ? vsel : est_q;
		end
		if (st_q == S_SCAN) begin
			if (s_q == '0) begin
				fnd_q   <= match;
				fidx_q  <= '0;
				lo_q    <= '0;
				locnt_q <= hcnt;
				lokey_q <= hkey;
				fill_q  <= FW'(hvld);
			end else begin
				if (match && !fnd_q) begin
					fnd_q  <= 1'b1;
					fidx_q <= s_q;
				end
				if (hvld && (hcnt < locnt_q)) begin
					lo_q    <= s_q;
					locnt_q <= hcnt;
					lokey_q <= hkey;
				end
				fill_q <= fill_q + FW'(hvld);
			end
		end
		if (acc || (st_q == S_DEC)) begin
			res_q <= res_d;
		end
		if (load) begin
			rsp_q <= (st_q == S_EMIT) ? res_q : dent;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

### design/cms_chk.sv
`include "count_min_sketch_top_k_defines.svh"

module cms_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input cms_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input cms_pkg::rsp_t rsp
);

	`CMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`CMS_ASSERT_NEXT(a_busy_after_beat, req_valid && !req_stall, req_stall)
	`CMS_ASSERT_NOW(a_entry_clean, rsp_valid && rsp.entry_valid, rsp.estimate == 32'd0 && !rsp.tracked && !rsp.evicted_valid)
	`CMS_ASSERT_NOW(a_evict_tracked, rsp_valid && rsp.evicted_valid, rsp.tracked && rsp.last && !rsp.entry_valid)

endmodule

bind count_min_sketch_top_k cms_chk u_cms_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
